// File: sv/assert_macros.svh
// Assertion macros used by the lock top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lock assertion failed");

// Property that must hold in the cycle after a trigger condition.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("lock assertion failed");

`endif

// File: sv/rlwf_pkg.sv
// Package with types, codes and defaults of the recursive lock with wait queue.
`timescale 1ns / 1ps

package rlwf_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int THREAD_COUNT_DEF = 64;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int THREAD_ID_W = 6;
    localparam int CMD_W       = 2;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 16;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONCE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_ACQUIRED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAILED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WRONG_KIND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_MODE_SET   = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [THREAD_ID_W-1:0] thread_id;
        logic                   release_kind;
        logic [MODE_W-1:0]      wakeup_mode;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   woken_valid;
        logic [THREAD_ID_W-1:0] woken_thread;
        logic [THREAD_ID_W-1:0] owner_now;
        logic [COUNT_OUT_W-1:0] count_now;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic clear;
        logic capture;
        logic exec;
        logic pop;
        logic wake;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic need_pop;
        logic wake_ok;
        logic fifo_nonempty;
        logic out_free;
        logic owner_zero;
        logic count_zero;
    } t_stat;

    // Configuration values and the reload strobe for the lock state.
    typedef struct packed {
        logic                   handle_kind;
        logic                   load_owner;
        logic [THREAD_ID_W-1:0] owner_value;
    } t_cfg;

endpackage

// File: sv/rlwf_ctrl.sv
// Controller state machine of the recursive lock.
`timescale 1ns / 1ps

module rlwf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rlwf_pkg::t_stat i_stat,
    output rlwf_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_POP   = 6'b001000,
        S_WAKE  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_pop ? S_POP : S_OUT;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_WAKE;
            end
            S_WAKE: begin
                o_cmd.wake = 1'b1;
                if (i_stat.wake_ok) begin
                    n_state = S_OUT;
                end else if (i_stat.fifo_nonempty) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: sv/rlwf_dp.sv
// Datapath of the recursive lock: owner, count, waiter queue and wake mode table.
`timescale 1ns / 1ps

module rlwf_dp #(
    parameter int QUEUE_DEPTH  = rlwf_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_COUNT = rlwf_pkg::THREAD_COUNT_DEF,
    parameter int COUNT_BITS   = rlwf_pkg::COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rlwf_pkg::t_cmd  i_cmd,
    input  rlwf_pkg::t_cfg  i_cfg,
    input  rlwf_pkg::t_in   i_in_data,
    input  logic            i_out_stall,
    output rlwf_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output rlwf_pkg::t_out  o_out_data
);

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TW  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int IDW = rlwf_pkg::THREAD_ID_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Captured command word.
    logic [rlwf_pkg::CMD_W-1:0]    r_cmd;
    logic [IDW-1:0]                r_tid;
    logic                          r_rkind;
    logic [rlwf_pkg::MODE_W-1:0]   r_mode;

    logic [IDW-1:0]                r_owner, n_owner;
    logic [COUNT_BITS-1:0]         r_count, n_count;
    logic [QW-1:0]                 r_head, n_head;
    logic [QW-1:0]                 r_tail, n_tail;
    logic [QW:0]                   r_fill, n_fill;
    logic [rlwf_pkg::STATUS_W-1:0] r_status, n_status;
    logic                          r_wvalid, n_wvalid;
    logic [IDW-1:0]                r_wthread, n_wthread;
    logic [TW-1:0]                 r_clr;
    logic                          r_out_valid;
    rlwf_pkg::t_out                r_out;

    logic [IDW-1:0]                r_fifo_mem [QUEUE_DEPTH];
    logic [IDW-1:0]                r_fifo_rd;
    logic [IDW-1:0]                r_cand;
    logic [rlwf_pkg::MODE_W-1:0]   r_mode_mem [THREAD_COUNT];
    logic [rlwf_pkg::MODE_W-1:0]   r_mode_rd;

    logic                          fifo_we;
    logic                          mode_we;
    logic [TW-1:0]                 mode_waddr;
    logic [rlwf_pkg::MODE_W-1:0]   mode_wdata;
    logic                          tid_ok;
    logic                          cand_ok;
    logic                          rel_ok;
    logic                          wake_ok;
    logic                          fifo_full;
    logic [QW-1:0]                 head_next;
    logic [QW-1:0]                 tail_next;

    assign tid_ok    = 32'(r_tid) < THREAD_COUNT;
    assign cand_ok   = 32'(r_cand) < THREAD_COUNT;
    assign rel_ok    = (r_rkind == i_cfg.handle_kind) && (r_tid != '0) && (r_owner == r_tid);
    assign wake_ok   = cand_ok && (r_mode_rd != rlwf_pkg::MODE_NONE);
    assign fifo_full = r_fill == (QW+1)'(QUEUE_DEPTH);
    assign head_next = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
    assign tail_next = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QW'(1);

    always_comb begin
        n_owner    = r_owner;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_status   = r_status;
        n_wvalid   = r_wvalid;
        n_wthread  = r_wthread;
        fifo_we    = 1'b0;
        mode_we    = i_cmd.clear;
        mode_waddr = r_clr;
        mode_wdata = rlwf_pkg::MODE_NONE;

        if (i_cmd.exec) begin
            n_wvalid  = 1'b0;
            n_wthread = '0;
            case (r_cmd)
                rlwf_pkg::CMD_ACQUIRE: begin
                    if (r_tid == '0) begin
                        n_status = rlwf_pkg::ST_FAILED;
                    end else if (r_owner == '0) begin
                        n_owner  = r_tid;
                        n_count  = COUNT_BITS'(1);
                        n_status = rlwf_pkg::ST_ACQUIRED;
                    end else if (r_owner == r_tid) begin
                        if (r_count == CNT_MAX) begin
                            n_status = rlwf_pkg::ST_FAILED;
                        end else begin
                            n_count  = r_count + COUNT_BITS'(1);
                            n_status = rlwf_pkg::ST_ACQUIRED;
                        end
                    end else if (fifo_full) begin
                        n_status = rlwf_pkg::ST_FAILED;
                    end else begin
                        fifo_we  = 1'b1;
                        n_tail   = tail_next;
                        n_fill   = r_fill + (QW+1)'(1);
                        n_status = rlwf_pkg::ST_QUEUED;
                    end
                end
                rlwf_pkg::CMD_RELEASE: begin
                    if (r_rkind != i_cfg.handle_kind) begin
                        n_status = rlwf_pkg::ST_WRONG_KIND;
                    end else if (!rel_ok) begin
                        n_status = rlwf_pkg::ST_NOT_OWNER;
                    end else begin
                        n_count  = r_count - COUNT_BITS'(1);
                        if (r_count == COUNT_BITS'(1)) begin
                            n_owner = '0;
                        end
                        n_status = rlwf_pkg::ST_RELEASED;
                    end
                end
                rlwf_pkg::CMD_SET_MODE: begin
                    if (tid_ok) begin
                        mode_we    = 1'b1;
                        mode_waddr = TW'(r_tid);
                        mode_wdata = r_mode;
                    end
                    n_status = rlwf_pkg::ST_MODE_SET;
                end
                default: begin
                    n_status = rlwf_pkg::ST_FAILED;
                end
            endcase
        end

        if (i_cmd.pop) begin
            n_head = head_next;
            n_fill = r_fill - (QW+1)'(1);
        end

        if (i_cmd.wake && wake_ok) begin
            n_owner   = r_cand;
            n_count   = COUNT_BITS'(1);
            n_wvalid  = 1'b1;
            n_wthread = r_cand;
            // A single wakeup is used up; repeated and the spare code stay.
            if (r_mode_rd == rlwf_pkg::MODE_ONCE) begin
                mode_we    = 1'b1;
                mode_waddr = TW'(r_cand);
                mode_wdata = rlwf_pkg::MODE_NONE;
            end
        end

        // Writing the initial owner rebuilds the lock and empties the queue.
        if (i_cfg.load_owner) begin
            n_owner = i_cfg.owner_value;
            n_count = (i_cfg.owner_value != '0) ? COUNT_BITS'(1) : '0;
            n_head  = '0;
            n_tail  = '0;
            n_fill  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner     <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_owner <= n_owner;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            if (i_cmd.clear) begin
                r_clr <= r_clr + TW'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_in_data.cmd;
            r_tid   <= i_in_data.thread_id;
            r_rkind <= i_in_data.release_kind;
            r_mode  <= i_in_data.wakeup_mode;
        end
        r_status  <= n_status;
        r_wvalid  <= n_wvalid;
        r_wthread <= n_wthread;
        if (i_cmd.pop) begin
            r_cand <= r_fifo_rd;
        end
        if (i_cmd.load) begin
            r_out.status       <= r_status;
            r_out.woken_valid  <= r_wvalid;
            r_out.woken_thread <= r_wthread;
            r_out.owner_now    <= r_owner;
            r_out.count_now    <= rlwf_pkg::COUNT_OUT_W'(r_count);
        end
    end

    // Waiter queue: written at the tail, read at the head every cycle.
    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            r_fifo_mem[r_tail] <= r_tid;
        end
        r_fifo_rd <= r_fifo_mem[r_head];
    end

    // Wake mode table: looked up at the waiter just read from the queue.
    always_ff @(posedge i_clk) begin
        if (mode_we) begin
            r_mode_mem[mode_waddr] <= mode_wdata;
        end
        r_mode_rd <= r_mode_mem[TW'(r_fifo_rd)];
    end

    assign o_stat.clear_done    = r_clr == TW'(THREAD_COUNT - 1);
    assign o_stat.need_pop      = (r_cmd == rlwf_pkg::CMD_RELEASE) && rel_ok
                                  && (r_count == COUNT_BITS'(1)) && (r_fill != '0);
    assign o_stat.wake_ok       = wake_ok;
    assign o_stat.fifo_nonempty = r_fill != '0;
    assign o_stat.out_free      = !r_out_valid || !i_out_stall;
    assign o_stat.owner_zero    = r_owner == '0;
    assign o_stat.count_zero    = r_count == '0;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/recursive_lock_with_wait_fifo.sv
// Top level of the recursive lock with a FIFO of waiting threads.
//
//   channel   direction  handshake                  word
//   in        input      i_in_valid / o_in_stall    rlwf_pkg::t_in
//   out       output     o_out_valid / i_out_stall  rlwf_pkg::t_out
//   cfg       APB write  psel, penable, pwrite      pwdata, handle kind / initial owner
//
// Every word holds the input while it is in work: the IDLE state accepts it,
// the EXEC state runs it and the OUT state loads its result register once the output is free.
// A release that frees the lock adds the POP and WAKE states for each waiter popped,
// the POP state reading the waiter's wake mode and the WAKE state waking it if allowed.
// After reset the wake mode table is cleared one entry a cycle, all THREAD_COUNT entries,
// while o_in_stall stays high; configuration writes are taken meanwhile.
// A stalled result holds its register; the next word is accepted meanwhile and waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module recursive_lock_with_wait_fifo #(
    parameter int QUEUE_DEPTH  = rlwf_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_COUNT = rlwf_pkg::THREAD_COUNT_DEF,
    parameter int COUNT_BITS   = rlwf_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rlwf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rlwf_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int IDW = rlwf_pkg::THREAD_ID_W;

    logic            r_handle_kind;
    logic [IDW-1:0]  r_init_owner;
    logic            cfg_wr;
    rlwf_pkg::t_cmd  s_cmd;
    rlwf_pkg::t_stat s_stat;
    rlwf_pkg::t_cfg  s_cfg;
    logic            out_woken;
    logic            woken_is_owner;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register index is address bit 2; the low bits are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handle_kind <= 1'b0;
            r_init_owner  <= '0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_init_owner <= pwdata[IDW-1:0];
            end else begin
                r_handle_kind <= pwdata[0];
            end
        end
    end

    assign prdata = paddr[2] ? 32'(r_init_owner) : 32'(r_handle_kind);

    assign s_cfg.handle_kind = r_handle_kind;
    assign s_cfg.load_owner  = cfg_wr && paddr[2];
    assign s_cfg.owner_value = pwdata[IDW-1:0];

    rlwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    rlwf_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .THREAD_COUNT (THREAD_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .i_cfg       (s_cfg),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (s_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !s_cmd.idle;

    assign out_woken      = o_out_valid && o_out_data.woken_valid;
    assign woken_is_owner = (o_out_data.status == rlwf_pkg::ST_RELEASED)
                            && (o_out_data.woken_thread == o_out_data.owner_now);

    // The lock is owned exactly when its hold count is nonzero.
    `ASSERT_SYNC(a_owner_count, i_clk, i_rst_n, s_stat.owner_zero == s_stat.count_zero)

    // Only one word is in work at a time.
    `ASSERT_NEXT(a_accept_stalls, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A woken waiter comes only with a release and is the new owner.
    `ASSERT_SYNC(a_woken_owner, i_clk, i_rst_n, out_woken |-> woken_is_owner)

endmodule
